@@ rtl/dlpsa_pkg.sv @@
// ----------------------------------------------------------------------------
// dlpsa_pkg
// Shared types and constants for the debounced long-press standby arm block.
// ----------------------------------------------------------------------------
`default_nettype none

package dlpsa_pkg;

    // configuration register indexes
    localparam logic [7:0] CFG_DEBOUNCE = 8'd0;
    localparam logic [7:0] CFG_HOLD     = 8'd1;
    localparam logic [7:0] CFG_STARTUP  = 8'd2;
    localparam logic [7:0] CFG_BUZZER   = 8'd3;

    // configuration reset values
    localparam logic [15:0] DEBOUNCE_RST = 16'd10;
    localparam logic [15:0] HOLD_RST     = 16'd100;
    localparam logic [15:0] STARTUP_RST  = 16'd400;
    localparam logic [15:0] BUZZER_RST   = 16'd172;

    // mode codes seen on the result channel
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_HOLD  = 2'd1;
    localparam logic [1:0] MODE_ARMED = 2'd2;

    // one-hot sequencer state
    typedef enum logic [2:0] {
        SEQ_IDLE  = 3'b001,
        SEQ_HOLD  = 3'b010,
        SEQ_ARMED = 3'b100
    } seq_state_t;

    // configuration register bank contents
    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] hold_ticks;
        logic [15:0] startup_ticks;
        logic [15:0] buzzer_ticks;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic       stable_level;
        logic [1:0] mode;
        logic       motor_sleep_pulse;
        logic       standby_request;
        logic       off_enabled;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/dlpsa_cfg.sv @@
// ----------------------------------------------------------------------------
// dlpsa_cfg
// Configuration register bank, written through a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dlpsa_cfg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [7:0]     cfg_index,
    input  wire logic [15:0]    cfg_data,
    output dlpsa_pkg::cfg_t     cfg
);

    dlpsa_pkg::cfg_t cfg_reg;
    dlpsa_pkg::cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;

    // decode a write transfer
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                dlpsa_pkg::CFG_DEBOUNCE: cfg_next.debounce_ticks = cfg_data;
                dlpsa_pkg::CFG_HOLD:     cfg_next.hold_ticks     = cfg_data;
                dlpsa_pkg::CFG_STARTUP:  cfg_next.startup_ticks  = cfg_data;
                dlpsa_pkg::CFG_BUZZER:   cfg_next.buzzer_ticks   = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= dlpsa_pkg::DEBOUNCE_RST;
            cfg_reg.hold_ticks     <= dlpsa_pkg::HOLD_RST;
            cfg_reg.startup_ticks  <= dlpsa_pkg::STARTUP_RST;
            cfg_reg.buzzer_ticks   <= dlpsa_pkg::BUZZER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/dlpsa_core.sv @@
// ----------------------------------------------------------------------------
// dlpsa_core
// Per-tick state update: startup timer, debouncer, hold counter, sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dlpsa_core #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic           raw,
    input  wire dlpsa_pkg::cfg_t cfg,
    output dlpsa_pkg::result_t  res
);

    // compare width covers both the counters and the 16-bit registers
    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic                  last_raw_reg, last_raw_next;
    logic [COUNT_BITS-1:0] same_count_reg, same_count_next;
    logic                  debounced_reg, debounced_next;
    logic [COUNT_BITS-1:0] startup_count_reg, startup_count_next;
    logic                  enabled_reg, enabled_next;
    logic [COUNT_BITS-1:0] hold_count_reg, hold_count_next;
    logic [COUNT_BITS-1:0] wait_count_reg, wait_count_next;
    dlpsa_pkg::seq_state_t state_reg, state_next;
    logic                  pulse;
    logic [CW-1:0]         buzzer_ext;

    assign buzzer_ext = CW'(cfg.buzzer_ticks);

    // next state for one tick
    always_comb
    begin
        pulse = 1'b0;

        // startup timer, enable latches once set
        startup_count_next = (startup_count_reg == CNT_MAX) ? CNT_MAX
                                                            : startup_count_reg + CNT_ONE;
        enabled_next = enabled_reg
                     | (CW'(startup_count_next) > CW'(cfg.startup_ticks));

        // debouncer on both edges
        last_raw_next = raw;
        if (raw == last_raw_reg)
        begin
            same_count_next = (same_count_reg == CNT_MAX) ? CNT_MAX
                                                          : same_count_reg + CNT_ONE;
        end
        else
        begin
            same_count_next = '0;
        end
        debounced_next = (CW'(same_count_next) == CW'(cfg.debounce_ticks)) ? raw
                                                                            : debounced_reg;

        // standby sequencer
        state_next      = state_reg;
        hold_count_next = hold_count_reg;
        wait_count_next = wait_count_reg;
        case (state_reg)
            dlpsa_pkg::SEQ_IDLE:
            begin
                if (enabled_next)
                begin
                    if (debounced_next)
                    begin
                        hold_count_next = (hold_count_reg == CNT_MAX) ? CNT_MAX
                                                                      : hold_count_reg + CNT_ONE;
                        if (CW'(hold_count_next) >= CW'(cfg.hold_ticks))
                        begin
                            state_next      = dlpsa_pkg::SEQ_HOLD;
                            wait_count_next = buzzer_ext[COUNT_BITS-1:0];
                            pulse           = 1'b1;
                        end
                    end
                    else
                    begin
                        hold_count_next = '0;
                    end
                end
            end
            dlpsa_pkg::SEQ_HOLD:
            begin
                wait_count_next = wait_count_reg - CNT_ONE;
                if (wait_count_next == '0)
                begin
                    state_next = dlpsa_pkg::SEQ_ARMED;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    // state registers advance once per transfer into the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg      <= 1'b0;
            same_count_reg    <= '0;
            debounced_reg     <= 1'b0;
            startup_count_reg <= '0;
            enabled_reg       <= 1'b0;
            hold_count_reg    <= '0;
            wait_count_reg    <= '0;
            state_reg         <= dlpsa_pkg::SEQ_IDLE;
        end
        else if (step)
        begin
            last_raw_reg      <= last_raw_next;
            same_count_reg    <= same_count_next;
            debounced_reg     <= debounced_next;
            startup_count_reg <= startup_count_next;
            enabled_reg       <= enabled_next;
            hold_count_reg    <= hold_count_next;
            wait_count_reg    <= wait_count_next;
            state_reg         <= state_next;
        end
    end

    // result fields from the updated state
    always_comb
    begin
        res.stable_level      = debounced_next;
        res.motor_sleep_pulse = pulse;
        res.off_enabled       = enabled_next;
        res.standby_request   = (state_next == dlpsa_pkg::SEQ_ARMED);
        case (state_next)
            dlpsa_pkg::SEQ_IDLE:  res.mode = dlpsa_pkg::MODE_IDLE;
            dlpsa_pkg::SEQ_HOLD:  res.mode = dlpsa_pkg::MODE_HOLD;
            dlpsa_pkg::SEQ_ARMED: res.mode = dlpsa_pkg::MODE_ARMED;
            default:              res.mode = dlpsa_pkg::MODE_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/debounced_long_press_standby_arm.sv @@
// ----------------------------------------------------------------------------
// debounced_long_press_standby_arm
// Button debouncer with long-press detection that arms a standby request.
// ----------------------------------------------------------------------------
// One raw button sample is taken per transfer and one result comes back per
// sample, in order. The block sustains one sample per clock while the result
// side is not stalled: a sample is captured in the input register, the counter
// update in the core computes the new state combinationally, and the result is
// held in the output register until taken. With the result side stalled, the
// input register still takes one more sample before in_ready drops.
// Configuration writes are taken every cycle and take effect from the next
// processed sample; write them only while idle.
`default_nettype none

module debounced_long_press_standby_arm #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sample channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        pressed,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             stable_level,
    output logic [1:0]       mode,
    output logic             motor_sleep_pulse,
    output logic             standby_request,
    output logic             off_enabled,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    dlpsa_pkg::cfg_t    cfg;
    dlpsa_pkg::result_t res;
    dlpsa_pkg::result_t res_reg;
    logic               in_valid_reg;
    logic               raw_reg;
    logic               out_valid_reg;
    logic               step;

    // register bank
    dlpsa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // pipeline flow control
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            raw_reg <= pressed;
        end
    end

    // state update
    dlpsa_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .raw   (raw_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign stable_level      = res_reg.stable_level;
    assign mode              = res_reg.mode;
    assign motor_sleep_pulse = res_reg.motor_sleep_pulse;
    assign standby_request   = res_reg.standby_request;
    assign off_enabled       = res_reg.off_enabled;

    // the pulse only comes with the move into the buzzer wait
    a_pulse_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && motor_sleep_pulse) |-> (mode == dlpsa_pkg::MODE_HOLD))
        else $error("motor sleep pulse outside buzzer wait");

    // standby request tracks the armed mode
    a_standby_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (standby_request == (mode == dlpsa_pkg::MODE_ARMED)))
        else $error("standby request does not match mode");

    // input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without result backpressure");

    // a power-off enable never drops between consecutive results
    a_enable_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_reg.off_enabled && out_valid) |=> res_reg.off_enabled)
        else $error("off enable cleared");

endmodule

`default_nettype wire

@@ tb/sv/debounced_long_press_standby_arm_tb.sv @@
// ----------------------------------------------------------------------------
// debounced_long_press_standby_arm_tb
// Self-checking bench for the button debouncer and standby arming sequence.
// ----------------------------------------------------------------------------
// Samples go in over a valid/ready channel with random bursts and gaps, and
// results are drained with a changing stall pattern plus one long hold-off.
// A per-sample model of the debouncer, startup, hold and buzzer counters
// predicts each result not fixed by the plan, checked field by field in
// order. The run starts with a short directed plan, then a steady released
// stretch with full debounce, then random phases under varied settings,
// and ends by triggering the long press once and waiting until armed.
`default_nettype none

module debounced_long_press_standby_arm_tb;

    localparam logic [15:0] CNT_MAX         = 16'hFFFF;
    localparam logic [7:0]  CFG_UNUSED      = 8'hFF;
    localparam int          SETTLE_CYCLES   = 4;
    localparam int          TAIL_CYCLES     = 8;
    localparam int          WATCHDOG_LIMIT  = 4000;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          PHASE_ITEMS     = 100;
    localparam int          STEADY_ITEMS    = 40;
    localparam int          MAX_PRINTED     = 20;

    // expected result right after reset: everything low and idle
    localparam dlpsa_pkg::result_t AT_RESET   =
        {1'b0, dlpsa_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0};
    // pressed level taken at once with zero debounce, still disabled
    localparam dlpsa_pkg::result_t TAKEN_HIGH =
        {1'b1, dlpsa_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0};

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [7:0]         idx;
        logic [15:0]        data;
        logic               pressed;
        logic [7:0]         reps;
        logic               fixed;
        dlpsa_pkg::result_t want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        pressed = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        stable_level;
    logic [1:0]  mode;
    logic        motor_sleep_pulse;
    logic        standby_request;
    logic        off_enabled;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'd0;
    logic [15:0] cfg_data = 16'd0;

    debounced_long_press_standby_arm u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .pressed           (pressed),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .stable_level      (stable_level),
        .mode              (mode),
        .motor_sleep_pulse (motor_sleep_pulse),
        .standby_request   (standby_request),
        .off_enabled       (off_enabled),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // model copy of the registers and the block state
    dlpsa_pkg::cfg_t regs = {dlpsa_pkg::DEBOUNCE_RST, dlpsa_pkg::HOLD_RST,
                             dlpsa_pkg::STARTUP_RST, dlpsa_pkg::BUZZER_RST};
    logic        raw_prev = 1'b0;
    logic [15:0] steady_cnt = 16'd0;
    logic        level = 1'b0;
    logic [15:0] tick_cnt = 16'd0;
    logic        off_en = 1'b0;
    logic [15:0] press_cnt = 16'd0;
    logic [1:0]  seq_mode = dlpsa_pkg::MODE_IDLE;
    logic [15:0] buzz_left = 16'd0;

    dlpsa_pkg::result_t due_results[$];
    plan_row_t          plan[$];
    int          err_count = 0;
    int          n_results = 0;
    int          n_samples = 0;
    int          n_writes = 0;
    int          level_changes = 0;
    int          burst_left = 0;
    bit          hold_off_req = 1'b0;
    bit          hold_off_done = 1'b0;

    // one tick of the button logic, returns the result it produces
    function automatic dlpsa_pkg::result_t step_button(input logic raw);
        dlpsa_pkg::result_t r;
        logic    pulse;
        logic    prior;
        pulse = 1'b0;
        prior = level;
        if (tick_cnt != CNT_MAX)
            tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt > regs.startup_ticks)
            off_en = 1'b1;
        // debouncer takes the raw level after exactly the configured run
        if (raw == raw_prev)
        begin
            if (steady_cnt != CNT_MAX)
                steady_cnt = steady_cnt + 16'd1;
        end
        else
        begin
            steady_cnt = 16'd0;
            raw_prev = raw;
        end
        if (steady_cnt == regs.debounce_ticks)
            level = raw;
        if (level != prior)
            level_changes++;
        // long-press sequence
        case (seq_mode)
            dlpsa_pkg::MODE_IDLE:
            begin
                if (off_en)
                begin
                    if (level)
                    begin
                        if (press_cnt != CNT_MAX)
                            press_cnt = press_cnt + 16'd1;
                        if (press_cnt >= regs.hold_ticks)
                        begin
                            seq_mode = dlpsa_pkg::MODE_HOLD;
                            buzz_left = regs.buzzer_ticks;
                            pulse = 1'b1;
                        end
                    end
                    else
                    begin
                        press_cnt = 16'd0;
                    end
                end
            end
            dlpsa_pkg::MODE_HOLD:
            begin
                buzz_left = buzz_left - 16'd1;
                if (buzz_left == 16'd0)
                    seq_mode = dlpsa_pkg::MODE_ARMED;
            end
            default:
            begin
            end
        endcase
        r.stable_level = level;
        r.mode = seq_mode;
        r.motor_sleep_pulse = pulse;
        r.standby_request = (seq_mode == dlpsa_pkg::MODE_ARMED);
        r.off_enabled = off_en;
        return r;
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [7:0] idx,
                                    input logic [15:0] data, input logic p,
                                    input int reps, input logic fixed,
                                    input dlpsa_pkg::result_t want);
        plan_row_t row;
        row.kind = kind;
        row.idx = idx;
        row.data = data;
        row.pressed = p;
        row.reps = reps[7:0];
        row.fixed = fixed;
        row.want = want;
        plan.push_back(row);
    endfunction

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
            $display("MISMATCH at result %0d: %s", n_results, msg);
        err_count++;
    endtask

    // one sample transfer, with the sender's bursts and gaps
    task automatic send_sample(input logic p, input logic fixed = 1'b0,
                               input dlpsa_pkg::result_t want = '0);
        dlpsa_pkg::result_t r;
        int      gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        pressed <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        r = step_button(p);
        due_results.push_back(fixed ? want : r);
        n_samples++;
    endtask

    // register write, only once every pending result has come back
    task automatic cfg_write(input logic [7:0] idx, input logic [15:0] val);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            dlpsa_pkg::CFG_DEBOUNCE: regs.debounce_ticks = val;
            dlpsa_pkg::CFG_HOLD:     regs.hold_ticks = val;
            dlpsa_pkg::CFG_STARTUP:  regs.startup_ticks = val;
            dlpsa_pkg::CFG_BUZZER:   regs.buzzer_ticks = val;
            default:
            begin
            end
        endcase
        n_writes++;
    endtask

    // runs of clean levels, bounces and noise
    task automatic drive_runs(input int n_items, input int db);
        int   sent;
        int   len;
        int   sel;
        int   i;
        logic lvl;
        sent = 0;
        lvl = ($urandom_range(0, 1) == 1);
        while (sent < n_items)
        begin
            sel = $urandom_range(0, 7);
            if (sel < 5)
                len = $urandom_range(db + 1, db + 12);
            else if (sel < 7)
                len = $urandom_range(1, (db > 0) ? db : 1);
            else
                len = $urandom_range(1, 6);
            for (i = 0; i < len && sent < n_items; i++)
            begin
                send_sample((sel == 7) ? ($urandom_range(0, 1) == 1) : lvl);
                sent++;
            end
            lvl = ~lvl;
        end
    endtask

    // random phase: new settings, hold kept out of reach of this phase
    task automatic run_phase(input int n_items, input bit with_hold_off);
        logic [15:0] db;
        int          sel;
        int          lo;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            db = 16'd0;
        else if (sel < 5)
            db = 16'($urandom_range(1, 4));
        else if (sel < 7)
            db = 16'($urandom_range(5, 12));
        else
            db = 16'($urandom_range(20, 40));
        cfg_write(dlpsa_pkg::CFG_DEBOUNCE, db);
        lo = press_cnt + n_items + 1;
        if ($urandom_range(0, 1) == 1)
            cfg_write(dlpsa_pkg::CFG_HOLD, 16'(lo + $urandom_range(0, 40)));
        else
            cfg_write(dlpsa_pkg::CFG_HOLD, 16'($urandom_range(lo, 65535)));
        if ($urandom_range(0, 2) == 0)
            cfg_write(dlpsa_pkg::CFG_BUZZER, 16'($urandom_range(0, 65535)));
        if ($urandom_range(0, 3) == 0)
            cfg_write(dlpsa_pkg::CFG_STARTUP, 16'($urandom_range(0, 65534)));
        if ($urandom_range(0, 3) == 0)
            cfg_write(8'($urandom_range(dlpsa_pkg::CFG_BUZZER + 1, 255)),
                      16'($urandom_range(0, 65535)));
        if (with_hold_off)
            hold_off_req = 1'b1;
        drive_runs(n_items, db);
    endtask

    // result receiver: changing stall styles, one long hold-off on request
    initial
    begin : receiver
        int left;
        int style;
        left = 0;
        style = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else
            begin
                if (left == 0)
                begin
                    style = $urandom_range(0, 3);
                    left = $urandom_range(32, 256);
                end
                left--;
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((left % 3) != 0);
                endcase
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin : result_check
        dlpsa_pkg::result_t got;
        dlpsa_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {stable_level, mode, motor_sleep_pulse, standby_request, off_enabled};
            if (due_results.size() == 0)
            begin
                report_mismatch("result transfer with nothing expected");
            end
            else
            begin
                want = due_results.pop_front();
                if (got.stable_level !== want.stable_level)
                    report_mismatch($sformatf("stable_level got %0b want %0b",
                                              got.stable_level, want.stable_level));
                if (got.mode !== want.mode)
                    report_mismatch($sformatf("mode got %0d want %0d",
                                              got.mode, want.mode));
                if (got.motor_sleep_pulse !== want.motor_sleep_pulse)
                    report_mismatch($sformatf("motor_sleep_pulse got %0b want %0b",
                                              got.motor_sleep_pulse,
                                              want.motor_sleep_pulse));
                if (got.standby_request !== want.standby_request)
                    report_mismatch($sformatf("standby_request got %0b want %0b",
                                              got.standby_request, want.standby_request));
                if (got.off_enabled !== want.off_enabled)
                    report_mismatch($sformatf("off_enabled got %0b want %0b",
                                              got.off_enabled, want.off_enabled));
            end
            n_results++;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin : watchdog
        int idle_cycles;
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        plan_row_t   row;
        int          i;
        int          k;
        int          sel;
        logic [15:0] db;
        logic [15:0] fin_hold;
        logic [15:0] fin_buzz;

        // directed plan: reset values, zero and full debounce, disabled hold
        add_row(ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 1, 1'b1, AT_RESET);
        add_row(ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 1, 1'b1, AT_RESET);
        add_row(ROW_WRITE, dlpsa_pkg::CFG_STARTUP, 16'hFFFF, 1'b0, 0, 1'b0, '0);
        add_row(ROW_WRITE, dlpsa_pkg::CFG_HOLD, 16'hFFFF, 1'b0, 0, 1'b0, '0);
        add_row(ROW_WRITE, dlpsa_pkg::CFG_DEBOUNCE, 16'd0, 1'b0, 0, 1'b0, '0);
        add_row(ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 1, 1'b0, '0);
        add_row(ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 1, 1'b1, TAKEN_HIGH);
        add_row(ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 1, 1'b0, '0);
        add_row(ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 3, 1'b0, '0);
        add_row(ROW_WRITE, dlpsa_pkg::CFG_DEBOUNCE, 16'hFFFF, 1'b0, 0, 1'b0, '0);
        add_row(ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 3, 1'b0, '0);
        add_row(ROW_WRITE, dlpsa_pkg::CFG_DEBOUNCE, 16'd1, 1'b0, 0, 1'b0, '0);
        add_row(ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 1, 1'b0, '0);
        add_row(ROW_SAMPLE, 8'd0, 16'd0, 1'b0, 3, 1'b0, '0);
        add_row(ROW_WRITE, dlpsa_pkg::CFG_BUZZER, 16'd0, 1'b0, 0, 1'b0, '0);
        add_row(ROW_WRITE, dlpsa_pkg::CFG_BUZZER, 16'hFFFF, 1'b0, 0, 1'b0, '0);
        add_row(ROW_WRITE, dlpsa_pkg::CFG_BUZZER, 16'd1, 1'b0, 0, 1'b0, '0);
        add_row(ROW_WRITE, CFG_UNUSED, 16'hA5C3, 1'b0, 0, 1'b0, '0);
        add_row(ROW_WRITE, dlpsa_pkg::CFG_HOLD, 16'd1, 1'b0, 0, 1'b0, '0);
        add_row(ROW_SAMPLE, 8'd0, 16'd0, 1'b1, 4, 1'b0, '0);
        add_row(ROW_WRITE, dlpsa_pkg::CFG_HOLD, 16'hFFFF, 1'b0, 0, 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan.size(); i++)
        begin
            row = plan[i];
            if (row.kind == ROW_WRITE)
            begin
                cfg_write(row.idx, row.data);
            end
            else
            begin
                for (k = 0; k < row.reps; k++)
                    send_sample(row.pressed, row.fixed, row.want);
            end
        end

        // steady release with full debounce while power-off is still disabled
        cfg_write(dlpsa_pkg::CFG_DEBOUNCE, 16'hFFFF);
        for (i = 0; i < STEADY_ITEMS; i++)
            send_sample(1'b0);

        // try a near-top startup setting, then enable power-off with a low one
        cfg_write(dlpsa_pkg::CFG_DEBOUNCE, 16'd2);
        cfg_write(dlpsa_pkg::CFG_STARTUP, 16'hFFFE);
        cfg_write(dlpsa_pkg::CFG_STARTUP, 16'd0);

        for (i = 0; i < RANDOM_PHASES; i++)
            run_phase(PHASE_ITEMS, i == 2);

        // final long press: trigger once, count down the buzzer, stay armed
        db = 16'($urandom_range(0, 6));
        sel = $urandom_range(0, 2);
        if (sel == 0)
            fin_hold = 16'd0;
        else if (sel == 1)
            fin_hold = 16'd1;
        else
            fin_hold = 16'($urandom_range(2, 20));
        if ($urandom_range(0, 1) == 0)
            fin_buzz = 16'd1;
        else
            fin_buzz = 16'($urandom_range(2, 40));
        cfg_write(dlpsa_pkg::CFG_DEBOUNCE, db);
        cfg_write(dlpsa_pkg::CFG_BUZZER, fin_buzz);
        cfg_write(dlpsa_pkg::CFG_HOLD, fin_hold);
        while (seq_mode == dlpsa_pkg::MODE_IDLE)
            send_sample(1'b1);
        while (seq_mode != dlpsa_pkg::MODE_ARMED)
            drive_runs(16, db);
        drive_runs(40, db);

        // drain and let any stray result show up
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d samples, %0d register writes, %0d debounced level changes",
                 n_samples, n_writes, level_changes);
        $display("long press with hold %0d and buzzer %0d ticks ended in mode %0d",
                 fin_hold, fin_buzz, seq_mode);
        if (err_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("%0d mismatches", err_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
